// ===== rtl/aabb_affine_transform_unit_defines.svh =====
// Assertion macros for the box transform unit and its checker.
// No dependencies; include by bare file name.
`ifndef AABB_AFFINE_TRANSFORM_UNIT_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define AABB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AABB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aabb_pkg.sv =====
// Shared widths, register indexes and reset values for the box transform unit.
// No dependencies.
package aabb_pkg;

  localparam int COORD_W   = 16;
  localparam int COEF_W    = 16;
  localparam int OUT_W     = 21;
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SHIFT_W   = OUT_W + 2;
  localparam int FRAC_BITS = 12;
  localparam int NUM_AXES  = 3;
  localparam int ROW_W     = 64;
  localparam int CFG_IDX_W = 2;
  // Cycles from the accepting edge to the edge that takes the result.
  localparam int LATENCY   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

  localparam logic [ROW_W-1:0] ROW_X_RST = 64'h1000_0000_0000_0000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 64'h0000_0000_0001_0000;

  typedef struct packed {
    logic signed [COEF_W-1:0]  cx;
    logic signed [COEF_W-1:0]  cy;
    logic signed [COEF_W-1:0]  cz;
    logic signed [COORD_W-1:0] t;
  } row_t;

endpackage

// ===== rtl/aabb_affine_transform_unit.sv =====
// Top level of the box transform unit: bounds of an axis-aligned box under a
// 3x4 affine transform. Depends on aabb_pkg.
//
//  channel   handshake                 payload
//  -------   -----------------------   -------------------------------------
//  input     start && !busy            in_min_x/y/z, in_max_x/y/z
//  result    done (one-cycle strobe)   out_min_x/y/z, out_max_x/y/z
//  config    cfg_valid && cfg_ready    cfg_index, cfg_data
//
// One box is taken every cycle outside reset. A result passes the input,
// product, min/max and sum registers in turn before it reaches the ports.
// Per-axis extremes come from picking the smaller and larger of each
// coefficient times min or max, so no eight-corner search is needed.
// Synchronous reset clears the pipeline valids and loads the row registers;
// busy and !cfg_ready show only during reset. The receiver cannot stall.
module aabb_affine_transform_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_min_x,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_min_y,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_min_z,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_max_x,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_max_y,
  input  logic signed [aabb_pkg::COORD_W-1:0] in_max_z,
  output logic                                done,
  output logic signed [aabb_pkg::OUT_W-1:0]   out_min_x,
  output logic signed [aabb_pkg::OUT_W-1:0]   out_min_y,
  output logic signed [aabb_pkg::OUT_W-1:0]   out_min_z,
  output logic signed [aabb_pkg::OUT_W-1:0]   out_max_x,
  output logic signed [aabb_pkg::OUT_W-1:0]   out_max_y,
  output logic signed [aabb_pkg::OUT_W-1:0]   out_max_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aabb_pkg::ROW_W-1:0]          cfg_data
);

  localparam int NA = aabb_pkg::NUM_AXES;

  aabb_pkg::row_t rows [NA];

  logic                                stage_vld [3];
  logic signed [aabb_pkg::COORD_W-1:0] lo [NA];
  logic signed [aabb_pkg::COORD_W-1:0] hi [NA];
  logic signed [aabb_pkg::PROD_W-1:0]  prod_lo [NA][NA];
  logic signed [aabb_pkg::PROD_W-1:0]  prod_hi [NA][NA];
  logic signed [aabb_pkg::PROD_W-1:0]  term_mn [NA][NA];
  logic signed [aabb_pkg::PROD_W-1:0]  term_mx [NA][NA];
  logic signed [aabb_pkg::SUM_W-1:0]   sum_mn [NA];
  logic signed [aabb_pkg::SUM_W-1:0]   sum_mx [NA];
  logic signed [aabb_pkg::SHIFT_W-1:0] res_mn [NA];
  logic signed [aabb_pkg::SHIFT_W-1:0] res_mx [NA];
  logic signed [aabb_pkg::OUT_W-1:0]   out_mn [NA];
  logic signed [aabb_pkg::OUT_W-1:0]   out_mx [NA];
  logic                                out_vld;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // Row registers; an index beyond row_z is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= aabb_pkg::ROW_X_RST;
      rows[1] <= aabb_pkg::ROW_Y_RST;
      rows[2] <= aabb_pkg::ROW_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aabb_pkg::REG_ROW_X: rows[0] <= cfg_data;
        aabb_pkg::REG_ROW_Y: rows[1] <= cfg_data;
        aabb_pkg::REG_ROW_Z: rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld[0] <= 1'b0;
      stage_vld[1] <= 1'b0;
      stage_vld[2] <= 1'b0;
      out_vld      <= 1'b0;
    end else begin
      stage_vld[0] <= start && !busy;
      stage_vld[1] <= stage_vld[0];
      stage_vld[2] <= stage_vld[1];
      out_vld      <= stage_vld[2];
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      lo[0] <= in_min_x;
      lo[1] <= in_min_y;
      lo[2] <= in_min_z;
      hi[0] <= in_max_x;
      hi[1] <= in_max_y;
      hi[2] <= in_max_z;
    end
  end

  // Products of every coefficient with both bounds of its axis.
  always_ff @(posedge clk) begin
    for (int r = 0; r < NA; r++) begin
      prod_lo[r][0] <= aabb_pkg::PROD_W'(lo[0]) * aabb_pkg::PROD_W'(rows[r].cx);
      prod_lo[r][1] <= aabb_pkg::PROD_W'(lo[1]) * aabb_pkg::PROD_W'(rows[r].cy);
      prod_lo[r][2] <= aabb_pkg::PROD_W'(lo[2]) * aabb_pkg::PROD_W'(rows[r].cz);
      prod_hi[r][0] <= aabb_pkg::PROD_W'(hi[0]) * aabb_pkg::PROD_W'(rows[r].cx);
      prod_hi[r][1] <= aabb_pkg::PROD_W'(hi[1]) * aabb_pkg::PROD_W'(rows[r].cy);
      prod_hi[r][2] <= aabb_pkg::PROD_W'(hi[2]) * aabb_pkg::PROD_W'(rows[r].cz);
    end
  end

  // Each term is independent, so the corner extremes split per term.
  always_ff @(posedge clk) begin
    for (int r = 0; r < NA; r++) begin
      for (int c = 0; c < NA; c++) begin
        if (prod_lo[r][c] < prod_hi[r][c]) begin
          term_mn[r][c] <= prod_lo[r][c];
          term_mx[r][c] <= prod_hi[r][c];
        end else begin
          term_mn[r][c] <= prod_hi[r][c];
          term_mx[r][c] <= prod_lo[r][c];
        end
      end
    end
  end

  // Sum, floor shift, add translation. The true value fits OUT_W bits.
  always_comb begin
    for (int r = 0; r < NA; r++) begin
      sum_mn[r] = aabb_pkg::SUM_W'(term_mn[r][0]) + aabb_pkg::SUM_W'(term_mn[r][1])
                + aabb_pkg::SUM_W'(term_mn[r][2]);
      sum_mx[r] = aabb_pkg::SUM_W'(term_mx[r][0]) + aabb_pkg::SUM_W'(term_mx[r][1])
                + aabb_pkg::SUM_W'(term_mx[r][2]);
      res_mn[r] = aabb_pkg::SHIFT_W'(sum_mn[r] >>> aabb_pkg::FRAC_BITS)
                + aabb_pkg::SHIFT_W'(rows[r].t);
      res_mx[r] = aabb_pkg::SHIFT_W'(sum_mx[r] >>> aabb_pkg::FRAC_BITS)
                + aabb_pkg::SHIFT_W'(rows[r].t);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < NA; r++) begin
      out_mn[r] <= res_mn[r][aabb_pkg::OUT_W-1:0];
      out_mx[r] <= res_mx[r][aabb_pkg::OUT_W-1:0];
    end
  end

  assign done      = out_vld;
  assign out_min_x = out_mn[0];
  assign out_min_y = out_mn[1];
  assign out_min_z = out_mn[2];
  assign out_max_x = out_mx[0];
  assign out_max_y = out_mx[1];
  assign out_max_z = out_mx[2];

endmodule

// ===== rtl/aabb_checker.sv =====
// Port-level checker for the box transform unit, bound to the top level.
// Depends on aabb_pkg and aabb_affine_transform_unit_defines.svh.
`include "aabb_affine_transform_unit_defines.svh"

module aabb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [aabb_pkg::OUT_W-1:0] out_min_x,
  input logic signed [aabb_pkg::OUT_W-1:0] out_min_y,
  input logic signed [aabb_pkg::OUT_W-1:0] out_min_z,
  input logic signed [aabb_pkg::OUT_W-1:0] out_max_x,
  input logic signed [aabb_pkg::OUT_W-1:0] out_max_y,
  input logic signed [aabb_pkg::OUT_W-1:0] out_max_z
);

  localparam int LAT = aabb_pkg::LATENCY;

  logic xfer;
  logic ordered;

  assign xfer    = start && !busy;
  assign ordered = (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
                && (out_min_z <= out_max_z);

  // Every transfer is followed by its result.
  `AABB_ASSERT_NOW(a_result_follows, clk, rst, xfer, ##(LAT) done, "result missing")

  // No result without a matching earlier transfer.
  `AABB_ASSERT_NOW(a_no_spurious, clk, rst, done, $past(xfer, LAT), "result without transfer")

  // Outside reset the unit always takes a box.
  `AABB_ASSERT_NEXT(a_never_busy, clk, rst, 1'b1, !busy, "busy outside reset")

  // The least corner never lies above the greatest one, even for inverted boxes.
  `AABB_ASSERT_NOW(a_bounds_ordered, clk, rst, done, ordered, "min above max")

endmodule

bind aabb_affine_transform_unit aabb_checker u_aabb_checker (.*);
